// File: design/wrh_pkg.sv
// shared types and constants for the water ripple heightmap engine
// no dependencies; used by every module of the block
`default_nettype none

package wrh_pkg;

  // default grid size
  localparam int COLS_DEF = 32;
  localparam int ROWS_DEF = 16;

  // field widths
  localparam int HEIGHT_W = 8;
  localparam int DECAY_W  = 9;
  localparam int OPC_W    = 2;
  localparam int COLIDX_W = 5;
  localparam int ROWIDX_W = 4;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_DECAY = 1'b0;
  localparam logic [DECAY_W-1:0] DECAY_RST = 9'd225;

  // operation codes
  localparam logic [OPC_W-1:0] OP_TOUCH  = 2'd0;
  localparam logic [OPC_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ   = 2'd2;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd3;

  // input transaction
  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [COLIDX_W-1:0] col_index;
    logic [ROWIDX_W-1:0] row_index;
    logic [HEIGHT_W-1:0] touch_height;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [HEIGHT_W-1:0] cell_height;
    logic [OPC_W-1:0]    done_opcode;
  } out_t;

  // datapath commands
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_CLR_STEP,
    DP_TOUCH,
    DP_RD_CELL,
    DP_RD_EW,
    DP_RD_NS,
    DP_CALC,
    DP_WRITE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sw_last;
  } status_t;

endpackage

`default_nettype wire

// File: design/wrh_map_ram.sv
// one heightmap: single write port, two registered read ports
// uses wrh_pkg for the cell width
`default_nettype none

module wrh_map_ram #(
  parameter int DEPTH  = wrh_pkg::COLS_DEF * wrh_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [ADDR_W-1:0]             waddr_i,
  input  wire logic [wrh_pkg::HEIGHT_W-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0]             raddr0_i,
  input  wire logic [ADDR_W-1:0]             raddr1_i,
  output logic      [wrh_pkg::HEIGHT_W-1:0]  rdata0_o,
  output logic      [wrh_pkg::HEIGHT_W-1:0]  rdata1_o
);

  logic [wrh_pkg::HEIGHT_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

// File: design/wrh_datapath.sv
// datapath: both heightmaps, sweep address counters, neighbor math, result register
// uses wrh_pkg and wrh_map_ram; driven by wrh_ctrl commands
`default_nettype none

module wrh_datapath #(
  parameter int COLS = wrh_pkg::COLS_DEF,
  parameter int ROWS = wrh_pkg::ROWS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire wrh_pkg::in_t                 item_i,
  input  wire logic [wrh_pkg::DECAY_W-1:0]  decay_i,
  input  wire wrh_pkg::cmd_t                cmd_i,
  output wrh_pkg::status_t                  status_o,
  output logic                              result_valid_o,
  output wrh_pkg::out_t                     result_o
);

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int HW     = wrh_pkg::HEIGHT_W;
  localparam int PROD_W = (HW + 1) + wrh_pkg::DECAY_W;

  wrh_pkg::in_t      item_q;
  logic              cur_b_q;
  logic [ADDR_W-1:0] idx_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [HW:0]       sum_ew_q;
  logic [HW:0]       diff_q;
  logic              pos_q;
  logic              result_valid_q;
  wrh_pkg::out_t     result_q;

  // addressing of the latched cell
  logic [31:0]       lin_addr;
  logic [ADDR_W-1:0] cell_addr;
  logic              on_grid;

  assign lin_addr  = 32'(item_q.row_index) * 32'(COLS) + 32'(item_q.col_index);
  assign cell_addr = lin_addr[ADDR_W-1:0];
  assign on_grid   = (32'(item_q.col_index) < 32'(COLS)) && (32'(item_q.row_index) < 32'(ROWS));

  // sweep and clear end markers
  assign status_o.clr_last = (idx_q == ADDR_W'(CELLS - 1));
  assign status_o.sw_last  = (row_q == ROW_W'(ROWS - 2)) && (col_q == COL_W'(COLS - 2));

  // read addresses toward the current and previous map
  logic [ADDR_W-1:0] rd_cur0, rd_cur1, rd_prv;

  always_comb begin
    rd_cur0 = idx_q;
    rd_cur1 = idx_q;
    rd_prv  = idx_q;
    case (cmd_i.op)
      wrh_pkg::DP_RD_EW: begin
        rd_cur0 = idx_q - ADDR_W'(1);
        rd_cur1 = idx_q + ADDR_W'(1);
      end
      wrh_pkg::DP_RD_NS: begin
        rd_cur0 = idx_q - ADDR_W'(COLS);
        rd_cur1 = idx_q + ADDR_W'(COLS);
      end
      wrh_pkg::DP_RD_CELL: begin
        rd_cur0 = cell_addr;
      end
      default: begin
        rd_cur0 = idx_q;
      end
    endcase
  end

  // scaled result of one interior cell
  logic [PROD_W-1:0] prod;
  logic [HW+1:0]     scaled;
  logic [HW-1:0]     res;

  assign prod   = PROD_W'(diff_q) * PROD_W'(decay_i);
  assign scaled = prod[PROD_W-1:8];

  always_comb begin
    if (!pos_q) begin
      res = '0;
    end else if (scaled > (HW+2)'(255)) begin
      res = '1;
    end else begin
      res = scaled[HW-1:0];
    end
  end

  // write ports of both maps
  logic              we_cur, we_prv, we_clr;
  logic [ADDR_W-1:0] wa_cur;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] wa_a, wa_b;
  logic [HW-1:0]     wd_a, wd_b;

  assign we_clr = (cmd_i.op == wrh_pkg::DP_CLR_STEP);
  assign we_cur = (cmd_i.op == wrh_pkg::DP_TOUCH) && on_grid;
  assign we_prv = (cmd_i.op == wrh_pkg::DP_WRITE);
  assign wa_cur = cell_addr;

  always_comb begin
    we_a = we_clr;
    we_b = we_clr;
    wa_a = idx_q;
    wa_b = idx_q;
    wd_a = '0;
    wd_b = '0;
    if (!we_clr) begin
      if (cur_b_q) begin
        we_b = we_cur;
        wa_b = wa_cur;
        wd_b = item_q.touch_height;
        we_a = we_prv;
        wd_a = res;
      end else begin
        we_a = we_cur;
        wa_a = wa_cur;
        wd_a = item_q.touch_height;
        we_b = we_prv;
        wd_b = res;
      end
    end
  end

  logic [HW-1:0] a_rd0, a_rd1, b_rd0, b_rd1;

  wrh_map_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_map_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (wa_a),
    .wdata_i  (wd_a),
    .raddr0_i (cur_b_q ? rd_prv : rd_cur0),
    .raddr1_i (rd_cur1),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  wrh_map_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_map_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (wa_b),
    .wdata_i  (wd_b),
    .raddr0_i (cur_b_q ? rd_cur0 : rd_prv),
    .raddr1_i (rd_cur1),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  // read data seen through the current and previous map roles
  logic [HW-1:0] cur0, cur1, prv;

  assign cur0 = cur_b_q ? b_rd0 : a_rd0;
  assign cur1 = cur_b_q ? b_rd1 : a_rd1;
  assign prv  = cur_b_q ? a_rd0 : b_rd0;

  // neighbor average doubled, minus the previous value
  logic [HW+1:0] sum_all;
  logic [HW:0]   twice;

  assign sum_all = (HW+2)'(sum_ew_q) + (HW+2)'(cur0) + (HW+2)'(cur1);
  assign twice   = {sum_all[HW+1:2], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wrh_pkg::DP_RD_NS) begin
      sum_ew_q <= (HW+1)'(cur0) + (HW+1)'(cur1);
    end
    if (cmd_i.op == wrh_pkg::DP_CALC) begin
      pos_q  <= twice > (HW+1)'(prv);
      diff_q <= twice - (HW+1)'(prv);
    end
    if (cmd_i.op == wrh_pkg::DP_LATCH) begin
      item_q <= item_i;
    end
    if (cmd_i.finish) begin
      result_q.done_opcode <= item_q.opcode;
      result_q.cell_height <= ((item_q.opcode == wrh_pkg::OP_READ) && on_grid) ? cur0 : '0;
    end
  end

  // counters, map role and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_b_q        <= 1'b0;
      idx_q          <= '0;
      col_q          <= COL_W'(1);
      row_q          <= ROW_W'(1);
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.finish;
      case (cmd_i.op)
        wrh_pkg::DP_LATCH: begin
          idx_q <= (item_i.opcode == wrh_pkg::OP_UPDATE) ? ADDR_W'(COLS + 1) : '0;
          col_q <= COL_W'(1);
          row_q <= ROW_W'(1);
        end
        wrh_pkg::DP_CLR_STEP: begin
          idx_q <= idx_q + ADDR_W'(1);
        end
        wrh_pkg::DP_WRITE: begin
          if (status_o.sw_last) begin
            cur_b_q <= ~cur_b_q;
          end
          if (col_q == COL_W'(COLS - 2)) begin
            col_q <= COL_W'(1);
            row_q <= row_q + ROW_W'(1);
            idx_q <= idx_q + ADDR_W'(3);
          end else begin
            col_q <= col_q + COL_W'(1);
            idx_q <= idx_q + ADDR_W'(1);
          end
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

// File: design/wrh_ctrl.sv
// controller: sequences clearing, touch, read and update sweep
// uses wrh_pkg; issues commands to wrh_datapath
`default_nettype none

module wrh_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [wrh_pkg::OPC_W-1:0]  opcode_i,
  input  wire wrh_pkg::status_t           status_i,
  output logic                            busy_o,
  output wrh_pkg::cmd_t                   cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_TOUCH,
    S_RD_ADDR,
    S_RD_OUT,
    S_EW,
    S_NS,
    S_CALC,
    S_WRITE
  } state_e;

  state_e state_q, state_d;

  // next state and datapath command
  always_comb begin
    state_d      = state_q;
    cmd_o.op     = wrh_pkg::DP_NOP;
    cmd_o.finish = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.op = wrh_pkg::DP_CLR_STEP;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = wrh_pkg::DP_LATCH;
          case (opcode_i)
            wrh_pkg::OP_TOUCH:  state_d = S_TOUCH;
            wrh_pkg::OP_UPDATE: state_d = S_EW;
            wrh_pkg::OP_READ:   state_d = S_RD_ADDR;
            default:            state_d = S_CLR;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.op     = wrh_pkg::DP_CLR_STEP;
        cmd_o.finish = status_i.clr_last;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_TOUCH: begin
        cmd_o.op     = wrh_pkg::DP_TOUCH;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_RD_ADDR: begin
        cmd_o.op = wrh_pkg::DP_RD_CELL;
        state_d  = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_EW: begin
        cmd_o.op = wrh_pkg::DP_RD_EW;
        state_d  = S_NS;
      end
      S_NS: begin
        cmd_o.op = wrh_pkg::DP_RD_NS;
        state_d  = S_CALC;
      end
      S_CALC: begin
        cmd_o.op = wrh_pkg::DP_CALC;
        state_d  = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.op     = wrh_pkg::DP_WRITE;
        cmd_o.finish = status_i.sw_last;
        state_d      = status_i.sw_last ? S_IDLE : S_EW;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register; reset starts the map clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: design/water_ripple_heightmap_engine.sv
// top level of the water ripple heightmap engine: config register and block wiring
// uses wrh_pkg, wrh_ctrl and wrh_datapath
//
//   channel   | signals                                   | handshake
//   ----------+-------------------------------------------+-------------------------------
//   command   | start, busy, item_i                       | taken when start & !busy
//   result    | result_valid_o, result_o                  | one-cycle strobe, no back-pressure
//   config    | psel, penable, pwrite, paddr, pwdata, ... | APB, pready tied high
//
// touch, read, clear and update sweep each keep busy high until they finish; the sweep
// visits the interior cells one at a time in the states S_EW, S_NS, S_CALC and S_WRITE,
// an order set by the registered read ports of the heightmap memories.
// after reset a clearing pass zeroes both maps, busy stays high.
// the result strobe follows the last busy cycle; the receiver cannot stall it.
`default_nettype none

module water_ripple_heightmap_engine #(
  parameter int COLS = wrh_pkg::COLS_DEF,
  parameter int ROWS = wrh_pkg::ROWS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire wrh_pkg::in_t                      item_i,
  output logic                                   result_valid_o,
  output wrh_pkg::out_t                          result_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [wrh_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [wrh_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [wrh_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  logic [wrh_pkg::DECAY_W-1:0] decay_q;
  logic                        cfg_wr;
  logic                        reg_hit;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == wrh_pkg::REG_DECAY);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= wrh_pkg::DECAY_RST;
    end else if (cfg_wr && reg_hit) begin
      decay_q <= pwdata[wrh_pkg::DECAY_W-1:0];
    end
  end

  assign prdata = reg_hit ? wrh_pkg::APB_DATA_W'(decay_q) : '0;

  // controller and datapath
  wrh_pkg::cmd_t    cmd;
  wrh_pkg::status_t status;

  wrh_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .status_i (status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  wrh_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .decay_i        (decay_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// File: tb/water_ripple_heightmap_engine_tb.sv
// self-checking testbench for the water ripple heightmap engine
// drives touch, sweep, read and clear transactions and tracks both heightmaps in a scoreboard
// depends on wrh_pkg and water_ripple_heightmap_engine
`timescale 1ns / 100ps

module water_ripple_heightmap_engine_tb;
  import wrh_pkg::*;

  localparam int COLS          = COLS_DEF;
  localparam int ROWS          = ROWS_DEF;
  localparam int CELLS         = COLS * ROWS;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 700;
  localparam int NUM_PHASES    = 6;
  // worst case: every transaction a full sweep plus sender gaps, taken several times over
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int COL_MAX       = (1 << COLIDX_W) - 1;
  localparam int ROW_MAX       = (1 << ROWIDX_W) - 1;
  localparam int ITEM_W        = $bits(in_t);

  // scoreboard: tracks both heightmaps and queues the expected results
  class heightmap_tracker;
    logic [HEIGHT_W-1:0] maps [2][CELLS];
    bit                  cur_b;
    logic [DECAY_W-1:0]  decay;
    out_t                pending [$];
    int                  mismatches;
    int                  checked;

    function new();
      clear_maps();
      cur_b      = 1'b0;
      decay      = DECAY_RST;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void clear_maps();
      foreach (maps[m, i]) maps[m][i] = '0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // one damped wave step over the interior, result lands in the previous map
    function void sweep();
      int cur, prv, idx, sum, twice, old, res;
      cur = cur_b;
      prv = !cur_b;
      for (int r = 1; r < ROWS - 1; r++) begin
        for (int c = 1; c < COLS - 1; c++) begin
          idx   = r * COLS + c;
          sum   = int'(maps[cur][idx-1]) + int'(maps[cur][idx+1]) +
                  int'(maps[cur][idx-COLS]) + int'(maps[cur][idx+COLS]);
          twice = (sum / 4) * 2;
          old   = int'(maps[prv][idx]);
          if (twice <= old) begin
            res = 0;
          end else begin
            res = ((twice - old) * int'(decay)) >>> 8;
            if (res > 255) res = 255;
          end
          maps[prv][idx] = res[HEIGHT_W-1:0];
        end
      end
      cur_b = !cur_b;
    endfunction

    // apply an accepted command to the maps and queue its expected result
    function void note_command(in_t cmd);
      out_t exp;
      bit   on_grid;
      int   idx;
      exp.cell_height = '0;
      exp.done_opcode = cmd.opcode;
      on_grid = (int'(cmd.col_index) < COLS) && (int'(cmd.row_index) < ROWS);
      idx     = int'(cmd.row_index) * COLS + int'(cmd.col_index);
      case (cmd.opcode)
        OP_TOUCH: begin
          if (on_grid) maps[cur_b][idx] = cmd.touch_height;
        end
        OP_UPDATE: begin
          sweep();
        end
        OP_READ: begin
          if (on_grid) exp.cell_height = maps[cur_b][idx];
        end
        OP_CLEAR: begin
          clear_maps();
        end
      endcase
      pending.push_back(exp);
    endfunction

    // compare a result transaction with the oldest expectation
    function void check_done(out_t got);
      out_t exp;
      checked++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result op %0d height %0d", got.done_opcode,
                       got.cell_height));
        return;
      end
      exp = pending.pop_front();
      if (got.done_opcode !== exp.done_opcode)
        flag($sformatf("done_opcode expected %0d got %0d", exp.done_opcode,
                       got.done_opcode));
      if (got.cell_height !== exp.cell_height)
        flag($sformatf("op %0d cell_height expected %0d got %0d", exp.done_opcode,
                       exp.cell_height, got.cell_height));
    endfunction
  endclass

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cmd_start = 1'b0;
  in_t                   cmd_item  = '0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic                  cmd_busy;
  logic                  done_valid;
  out_t                  done_item;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  heightmap_tracker tracker = new();
  int cycles    = 0;
  int idle_pct  = 31;
  int op_count [4];
  int last_col  = 16;
  int last_row  = 8;
  int decays_set = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  water_ripple_heightmap_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (cmd_start),
    .busy           (cmd_busy),
    .item_i         (cmd_item),
    .result_valid_o (done_valid),
    .result_o       (done_item),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // result monitor, the receiver never stalls
  always @(posedge clk_i) begin
    if (rst_ni && done_valid) tracker.check_done(done_item);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               tracker.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_t make_cmd(logic [OPC_W-1:0] op, int col, int row, int h);
    in_t cmd;
    cmd.opcode       = op;
    cmd.col_index    = col[COLIDX_W-1:0];
    cmd.row_index    = row[ROWIDX_W-1:0];
    cmd.touch_height = h[HEIGHT_W-1:0];
    return cmd;
  endfunction

  // random command; touches and reads cluster around the last touch
  function automatic in_t random_cmd();
    int pick, col, row, h;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 60) begin
      col = last_col + int'($urandom_range(4)) - 2;
      row = last_row + int'($urandom_range(4)) - 2;
      if (col < 0) col = 0;
      if (col > COL_MAX) col = COL_MAX;
      if (row < 0) row = 0;
      if (row > ROW_MAX) row = ROW_MAX;
    end else begin
      col = $urandom_range(COL_MAX);
      row = $urandom_range(ROW_MAX);
    end
    case ($urandom_range(3))
      0:       h = 255;
      1:       h = 0;
      default: h = $urandom_range(255);
    endcase
    if (pick < 28) begin
      last_col = col;
      last_row = row;
      return make_cmd(OP_TOUCH, col, row, h);
    end
    if (pick < 44) return make_cmd(OP_UPDATE, col, row, h);
    if (pick < 97) return make_cmd(OP_READ, col, row, h);
    return make_cmd(OP_CLEAR, col, row, h);
  endfunction

  // hand one command to the block, with random idle cycles before it
  task automatic issue(in_t cmd);
    while ($urandom_range(99) < idle_pct) begin
      cmd_start <= 1'b0;
      cmd_item  <= ITEM_W'($urandom);
      @(posedge clk_i);
    end
    cmd_start <= 1'b1;
    cmd_item  <= cmd;
    @(posedge clk_i);
    while (cmd_busy) @(posedge clk_i);
    tracker.note_command(cmd);
    op_count[cmd.opcode]++;
  endtask

  // drop start and wait until every result is in and the block is idle
  task automatic settle();
    cmd_start <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0 || cmd_busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write the decay register, then read it back
  task automatic write_decay(logic [DECAY_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DECAY, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.decay = val;
    decays_set++;
    // back-to-back read transaction
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[DECAY_W-1:0] !== val)
      tracker.flag($sformatf("decay readback expected %0d got %0d", val,
                             prdata[DECAY_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [DECAY_W-1:0] phase_decay [NUM_PHASES];
    int per_phase;
    phase_decay = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd0, DECAY_RST};
    phase_decay[4] = DECAY_W'($urandom_range(256));
    per_phase = RANDOM_ITEMS / NUM_PHASES;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears both maps after reset with busy high
    settle();

    // directed: extremes, border cells, negative results, clear, reset decay
    issue(make_cmd(OP_READ, 0, 0, 0));
    issue(make_cmd(OP_READ, COL_MAX, ROW_MAX, 0));
    issue(make_cmd(OP_TOUCH, 0, 0, 255));
    issue(make_cmd(OP_TOUCH, COL_MAX, ROW_MAX, 255));
    issue(make_cmd(OP_TOUCH, 16, 8, 255));
    issue(make_cmd(OP_TOUCH, 15, 7, 8'hAA));
    issue(make_cmd(OP_READ, 0, 0, 0));
    issue(make_cmd(OP_READ, COL_MAX, ROW_MAX, 0));
    issue(make_cmd(OP_READ, 16, 8, 0));
    issue(make_cmd(OP_UPDATE, 0, 0, 0));
    issue(make_cmd(OP_READ, 16, 7, 0));
    issue(make_cmd(OP_READ, 0, 0, 0));
    issue(make_cmd(OP_UPDATE, COL_MAX, ROW_MAX, 255));
    issue(make_cmd(OP_READ, 0, 0, 0));
    issue(make_cmd(OP_READ, 16, 8, 0));
    issue(make_cmd(OP_READ, 17, 8, 0));
    issue(make_cmd(OP_TOUCH, COL_MAX, 0, 8'h0F));
    issue(make_cmd(OP_TOUCH, 0, ROW_MAX, 8'hF0));
    issue(make_cmd(OP_READ, COL_MAX, 0, 0));
    issue(make_cmd(OP_READ, 0, ROW_MAX, 0));
    issue(make_cmd(OP_CLEAR, 5, 5, 0));
    issue(make_cmd(OP_READ, 16, 7, 0));
    issue(make_cmd(OP_READ, 0, 0, 0));
    settle();

    // random phases, one decay setting each, one phase without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_decay(phase_decay[p]);
      idle_pct = (p == 2) ? 0 : 31;
      // start each phase with a strong drop in the middle of the grid
      last_col = $urandom_range(COLS - 3, 2);
      last_row = $urandom_range(ROWS - 3, 2);
      issue(make_cmd(OP_TOUCH, last_col, last_row, 255));
      for (int n = 1; n < per_phase; n++) issue(random_cmd());
      settle();
    end

    $display("covered %0d touches, %0d sweeps, %0d reads, %0d clears over %0d decay writes",
             op_count[OP_TOUCH], op_count[OP_UPDATE], op_count[OP_READ],
             op_count[OP_CLEAR], decays_set);
    $display("%0d results checked, %0d mismatches", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: water_ripple_heightmap_engine.f
design/wrh_pkg.sv
design/wrh_map_ram.sv
design/wrh_datapath.sv
design/wrh_ctrl.sv
design/water_ripple_heightmap_engine.sv
tb/water_ripple_heightmap_engine_tb.sv
